[sv/bst_pkg.sv]
// Package for the binary search table: table geometry, item structs and opcodes.
// Used by binary_search_table; depends on nothing else.
`default_nettype none

package bst_pkg;

    // Number of entries the table memory holds.
    localparam int TABLE_DEPTH = 1024;
    // Address width of the table memory.
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // Fixed field widths of the items and of the length register.
    localparam int IDX_W       = 10;
    localparam int POS_W       = 10;
    localparam int DATA_W      = 32;
    localparam int LEN_W       = 11;
    // Signed search bounds: they span -1 up to the largest length.
    localparam int BOUND_W     = LEN_W + 1;

    // Opcodes of an input item.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic signed [BOUND_W-1:0] t_bound;

    typedef struct packed {
        logic                     opcode;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_item;

endpackage

`default_nettype wire

[sv/bst_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; used by binary_search_table for the table entries.
`default_nettype none

module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/binary_search_table.sv]
// Top level of the binary search table: sequencer around one table memory.
// Depends on bst_pkg and bst_ram.
//
// Usage:
// The input channel (i_valid, o_stall, i_item) carries two kinds of item.
// A write item stores entry_value at entry_index of the table and gives no
// result. A search item looks up search_key in the first table_length
// entries, which should be sorted ascending, and gives exactly one result
// item (found, position) on the output channel (o_valid, i_stall, o_item).
// Position is 0 when the key is not found.
// Each probe of the search issues the read of the table memory in S_CHECK
// and then compares the registered read data with the key in S_CMP.
// A search holds o_stall high until its result enters the output register
// at the edge where o_stall falls. For 1024 entries a search makes at most
// 11 probes. The block works on one item at a time.
// The result sits in an output register, so a new item is taken while an
// earlier result still waits on a stalled receiver; a search that ends
// while that register is still full waits until it is taken.
// Reset clears table_length and empties the output register. The table
// contents are not cleared: searches must only probe written entries.
// table_length is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, as the block does not enforce this.
// Values above the table depth are treated as the full depth.
`default_nettype none

module binary_search_table (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input item channel.
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire bst_pkg::t_in_item     i_item,
    // Result item channel.
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output bst_pkg::t_out_item         o_item,
    // Configuration: table_length.
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [bst_pkg::LEN_W-1:0] i_cfg_wr_data
);

    import bst_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;  // take items
    localparam logic [1:0] S_CHECK = 2'd1;  // test bounds, issue the probe read
    localparam logic [1:0] S_CMP   = 2'd2;  // compare read data with the key
    localparam logic [1:0] S_DONE  = 2'd3;  // hand the result to the output register

    // Control registers.
    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_len;
    logic             r_out_valid, n_out_valid;

    // Search registers.
    t_bound                   r_low, n_low;
    t_bound                   r_high, n_high;
    t_bound                   r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_found, n_found;
    logic [POS_W-1:0]         r_pos, n_pos;
    t_out_item                r_out_item, n_out_item;

    logic                     accept;
    logic                     out_free;
    logic [LEN_W-1:0]         len_sat;
    t_bound                   len_b;
    logic signed [BOUND_W:0]  bound_sum;
    logic signed [DATA_W-1:0] probe_value;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    bst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.entry_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Items are only taken while the sequencer is idle; writes therefore
    // never overlap a probe read of the same entry.
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Writes go straight into the table on the accepting edge.
    assign ram_we    = accept && (i_item.opcode == OP_WRITE)
                       && (int'(i_item.entry_index) < TABLE_DEPTH);
    assign ram_waddr = ADDR_W'(i_item.entry_index);
    assign ram_raddr = ADDR_W'(r_mid);

    assign probe_value = $signed(ram_rdata);

    always_comb begin
        // A length beyond the table depth searches the whole table.
        if (int'(r_len) > TABLE_DEPTH) begin
            len_sat = LEN_W'(TABLE_DEPTH);
        end else begin
            len_sat = r_len;
        end
        len_b = $signed({1'b0, len_sat});
    end

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_mid       = r_mid;
        n_key       = r_key;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_stall;
        bound_sum   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.opcode == OP_SEARCH)) begin
                    // The first probe sits at length/2, not at (low+high)/2.
                    n_low   = '0;
                    n_high  = len_b - t_bound'(1);
                    n_mid   = len_b >>> 1;
                    n_key   = i_item.search_key;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_low <= r_high) begin
                    n_state = S_CMP;
                end else begin
                    // Bounds crossed, or the table is empty.
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (r_key == probe_value) begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_mid);
                    n_state = S_DONE;
                end else begin
                    if (r_key > probe_value) begin
                        n_low = r_mid + t_bound'(1);
                    end else begin
                        n_high = r_mid - t_bound'(1);
                    end
                    // Midpoint of the new bounds; it is only used while
                    // both bounds are non-negative.
                    bound_sum = {n_low[BOUND_W-1], n_low} + {n_high[BOUND_W-1], n_high};
                    n_mid     = bound_sum[BOUND_W:1];
                    n_state   = S_CHECK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_item.found    = r_found;
                    n_out_item.position = r_pos;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_high     <= n_high;
        r_mid      <= n_mid;
        r_key      <= n_key;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_out_item <= n_out_item;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // The compare step always comes in the cycle after the probe read is issued.
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_CHECK))
        else $error("compare step without a preceding probe read");

    // Every probe lies between the current bounds.
    a_probe_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHECK) && (r_low <= r_high))
        |-> ((r_mid >= r_low) && (r_mid <= r_high)))
        else $error("probe position outside the search bounds");

    // A compare step only narrows the search window.
    a_window_narrows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> ((r_low >= $past(r_low)) && (r_high <= $past(r_high))))
        else $error("search window widened");

endmodule

`default_nettype wire
